/* src/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender window package
// Shared constants, request and register codes, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

   // Default size of the circular sequence space.
   localparam int SEQ_SPACE_DEF = 20;

   // Field widths fixed by the interface.
   localparam int REQ_TYPE_W  = 2;
   localparam int ACK_W       = 8;
   localparam int SEQ_OUT_W   = 5;
   localparam int WIN_W       = 5;
   localparam int PKT_W       = 16;
   localparam int LIMIT_W     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // Width used for comparisons that mix the window register, the ack byte
   // and the sequence space size.
   localparam int CMP_W = 9;

   // Request types.
   localparam logic [REQ_TYPE_W-1:0] REQ_START = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SEND  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_ACK   = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_POLL  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 2'd2;

   // Configuration reset values.
   localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST   = 5'd10;
   localparam logic [PKT_W-1:0]   TOTAL_PACKETS_RST = 16'd0;
   localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 8'd20;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the request being transferred
      logic exec;       // evaluate the latched request
      logic span_step;  // re-mark one sequence of the pending span
      logic load_out;   // move the result into the output register
   } gbn_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic span_req;   // the latched request needs a re-mark span
      logic span_last;  // the current span step is the final one
      logic out_free;   // the output register can take a new result
   } gbn_status_type;

endpackage

`default_nettype wire

/* src/gbn_ctrl.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender window controller
// Sequences each request through capture, evaluation, an optional re-mark
// span of one sequence per cycle, and hand-over to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire gbn_pkg::gbn_status_type status,
   output gbn_pkg::gbn_cmd_type         cmd
);
   import gbn_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SPAN = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.span_req ? ST_SPAN : ST_FIN;
         end
         ST_SPAN: begin
            cmd.span_step = 1'b1;
            if (status.span_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* src/gbn_datapath.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender window datapath
// Holds the window state, the acknowledged marks and the configuration, and
// computes each result under the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_datapath #(
   parameter int SEQ_SPACE = gbn_pkg::SEQ_SPACE_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [gbn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [gbn_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [gbn_pkg::REQ_TYPE_W-1:0]      req_type,
   input  wire logic [gbn_pkg::ACK_W-1:0]           req_ack_value,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic                                     rsp_send_valid,
   output logic [gbn_pkg::SEQ_OUT_W-1:0]            rsp_send_seq,
   output logic [gbn_pkg::PKT_W-1:0]                rsp_packet_index,
   output logic                                     rsp_timed_out,
   output logic                                     rsp_ack_ignored,
   output logic [gbn_pkg::SEQ_OUT_W-1:0]            rsp_window_base,
   output logic                                     rsp_done_res,
   input  wire gbn_pkg::gbn_cmd_type                cmd,
   output gbn_pkg::gbn_status_type                  status
);
   import gbn_pkg::*;

   localparam int SW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
   localparam int CW = $clog2(SEQ_SPACE + 1);
   localparam logic [SW-1:0]    SEQ_LAST  = SW'(SEQ_SPACE - 1);
   localparam logic [CMP_W-1:0] SPACE_CMP = CMP_W'(SEQ_SPACE);
   localparam logic [CMP_W-1:0] WMAX_CMP  = CMP_W'(SEQ_SPACE - 1);

   // Circular distance a - b over the sequence space.
   function automatic logic [SW-1:0] circ_dist(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
      logic [SW:0] diff;
      diff = {1'b0, a} - {1'b0, b};
      if (diff[SW]) begin
         diff = diff + (SW+1)'(SEQ_SPACE);
      end
      return diff[SW-1:0];
   endfunction

   // Step one place forward with wrap.
   function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] a);
      return (a == SEQ_LAST) ? '0 : a + SW'(1);
   endfunction

   // Configuration.
   logic [WIN_W-1:0]   win_ff;
   logic [PKT_W-1:0]   total_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // Window state.
   logic [SEQ_SPACE-1:0] marks_ff, marks_in;
   logic [SW-1:0]        base_ff, base_in;
   logic [SW-1:0]        next_ff, next_in;
   logic [PKT_W-1:0]     sent_ff, sent_in;
   logic [LIMIT_W-1:0]   idle_ff, idle_in;
   logic [CW-1:0]        unmarked_ff, unmarked_in;

   // Span walker.
   logic [SW-1:0] ptr_ff, ptr_in;
   logic [SW-1:0] remain_ff, remain_in;

   // Latched request.
   logic [REQ_TYPE_W-1:0] type_ff, type_in;
   logic [ACK_W-1:0]      ack_ff, ack_in;

   // Result held until hand-over.
   logic             res_sv_ff, res_sv_in;
   logic [SW-1:0]    res_seq_ff, res_seq_in;
   logic [PKT_W-1:0] res_pidx_ff, res_pidx_in;
   logic             res_tmo_ff, res_tmo_in;
   logic             res_ign_ff, res_ign_in;

   // Output register.
   logic                 out_valid_ff, out_valid_in;
   logic                 out_sv_ff, out_sv_in;
   logic [SEQ_OUT_W-1:0] out_seq_ff, out_seq_in;
   logic [PKT_W-1:0]     out_pidx_ff, out_pidx_in;
   logic                 out_tmo_ff, out_tmo_in;
   logic                 out_ign_ff, out_ign_in;
   logic [SEQ_OUT_W-1:0] out_base_ff, out_base_in;
   logic                 out_done_ff, out_done_in;

   // Decisions on the latched request.
   logic [SW-1:0]    outstanding;
   logic [CMP_W-1:0] weff;
   logic             grant;
   logic [CMP_W-1:0] ack_cmp;
   logic             ack_bad;
   logic [SW-1:0]    ack_seq;
   logic [SW-1:0]    ack_dist;
   logic             ack_used;
   logic [CMP_W-1:0] poll_next;
   logic             poll_tmo;
   logic [PKT_W-1:0] sent_rewind;

   always_comb begin
      outstanding = circ_dist(next_ff, base_ff);
      weff        = (CMP_W'(win_ff) < WMAX_CMP) ? CMP_W'(win_ff) : WMAX_CMP;
      grant       = (CMP_W'(outstanding) < weff) && marks_ff[next_ff] &&
                    (sent_ff < total_ff);
      ack_cmp     = CMP_W'(ack_ff);
      ack_bad     = (ack_ff == '0) || (ack_cmp > SPACE_CMP);
      ack_seq     = SW'(ack_cmp - CMP_W'(1));
      ack_dist    = circ_dist(ack_seq, base_ff);
      ack_used    = !ack_bad && (ack_dist < outstanding);
      poll_next   = CMP_W'(idle_ff) + CMP_W'(1);
      poll_tmo    = poll_next > CMP_W'(limit_ff);
      sent_rewind = (sent_ff >= PKT_W'(outstanding)) ?
                    sent_ff - PKT_W'(outstanding) : '0;
   end

   // Status to the controller.
   always_comb begin
      status.span_req  = ((type_ff == REQ_ACK) && ack_used) ||
                         ((type_ff == REQ_POLL) && poll_tmo && (outstanding != '0));
      status.span_last = (remain_ff == SW'(1));
      status.out_free  = !out_valid_ff || rsp_ready;
   end

   // Next-state logic of the window, the span walker and the result.
   always_comb begin
      marks_in    = marks_ff;
      base_in     = base_ff;
      next_in     = next_ff;
      sent_in     = sent_ff;
      idle_in     = idle_ff;
      unmarked_in = unmarked_ff;
      ptr_in      = ptr_ff;
      remain_in   = remain_ff;
      type_in     = type_ff;
      ack_in      = ack_ff;
      res_sv_in   = res_sv_ff;
      res_seq_in  = res_seq_ff;
      res_pidx_in = res_pidx_ff;
      res_tmo_in  = res_tmo_ff;
      res_ign_in  = res_ign_ff;

      if (cmd.capture) begin
         type_in = req_type;
         ack_in  = req_ack_value;
      end

      if (cmd.exec) begin
         res_sv_in   = 1'b0;
         res_seq_in  = '0;
         res_pidx_in = '0;
         res_tmo_in  = 1'b0;
         res_ign_in  = 1'b0;
         unique case (type_ff)
            REQ_START: begin
               marks_in    = '1;
               base_in     = '0;
               next_in     = '0;
               sent_in     = '0;
               idle_in     = '0;
               unmarked_in = '0;
            end
            REQ_SEND: begin
               if (grant) begin
                  res_sv_in         = 1'b1;
                  res_seq_in        = next_ff;
                  res_pidx_in       = sent_ff;
                  marks_in[next_ff] = 1'b0;
                  unmarked_in       = unmarked_ff + CW'(1);
                  next_in           = seq_inc(next_ff);
                  sent_in           = sent_ff + PKT_W'(1);
               end
            end
            REQ_ACK: begin
               idle_in = '0;
               if (ack_bad) begin
                  res_ign_in = 1'b1;
               end else if (ack_used) begin
                  // Cumulative ack: re-mark from the base through the acked sequence.
                  ptr_in    = base_ff;
                  remain_in = ack_dist + SW'(1);
                  base_in   = (ack_cmp == SPACE_CMP) ? '0 : SW'(ack_ff);
               end
            end
            REQ_POLL: begin
               if (poll_tmo) begin
                  // Go back: re-mark the outstanding span and rewind to the base.
                  idle_in     = '0;
                  ptr_in      = base_ff;
                  remain_in   = outstanding;
                  sent_in     = sent_rewind;
                  next_in     = base_ff;
                  res_tmo_in  = 1'b1;
                  res_pidx_in = sent_rewind;
               end else begin
                  idle_in = LIMIT_W'(poll_next);
               end
            end
            default: begin
               idle_in = idle_ff;
            end
         endcase
      end

      // One sequence of the span is re-marked per cycle.
      if (cmd.span_step) begin
         if (!marks_ff[ptr_ff]) begin
            unmarked_in = unmarked_ff - CW'(1);
         end
         marks_in[ptr_ff] = 1'b1;
         ptr_in           = seq_inc(ptr_ff);
         remain_in        = remain_ff - SW'(1);
      end
   end

   // Output register next values.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_sv_in    = out_sv_ff;
      out_seq_in   = out_seq_ff;
      out_pidx_in  = out_pidx_ff;
      out_tmo_in   = out_tmo_ff;
      out_ign_in   = out_ign_ff;
      out_base_in  = out_base_ff;
      out_done_in  = out_done_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_sv_in    = res_sv_ff;
         out_seq_in   = SEQ_OUT_W'(res_seq_ff);
         out_pidx_in  = res_pidx_ff;
         out_tmo_in   = res_tmo_ff;
         out_ign_in   = res_ign_ff;
         out_base_in  = SEQ_OUT_W'(base_ff);
         out_done_in  = (sent_ff == total_ff) && (unmarked_ff == '0);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= WINDOW_SIZE_RST;
         total_ff     <= TOTAL_PACKETS_RST;
         limit_ff     <= TIMEOUT_LIMIT_RST;
         marks_ff     <= '1;
         base_ff      <= '0;
         next_ff      <= '0;
         sent_ff      <= '0;
         idle_ff      <= '0;
         unmarked_ff  <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_WINDOW_SIZE:   win_ff   <= csr_wdata[WIN_W-1:0];
               CSR_TOTAL_PACKETS: total_ff <= csr_wdata[PKT_W-1:0];
               CSR_TIMEOUT_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
               default:           limit_ff <= limit_ff;
            endcase
         end
         marks_ff     <= marks_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         sent_ff      <= sent_in;
         idle_ff      <= idle_in;
         unmarked_ff  <= unmarked_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      type_ff     <= type_in;
      ack_ff      <= ack_in;
      res_sv_ff   <= res_sv_in;
      res_seq_ff  <= res_seq_in;
      res_pidx_ff <= res_pidx_in;
      res_tmo_ff  <= res_tmo_in;
      res_ign_ff  <= res_ign_in;
      out_sv_ff   <= out_sv_in;
      out_seq_ff  <= out_seq_in;
      out_pidx_ff <= out_pidx_in;
      out_tmo_ff  <= out_tmo_in;
      out_ign_ff  <= out_ign_in;
      out_base_ff <= out_base_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_send_valid   = out_sv_ff;
   assign rsp_send_seq     = out_seq_ff;
   assign rsp_packet_index = out_pidx_ff;
   assign rsp_timed_out    = out_tmo_ff;
   assign rsp_ack_ignored  = out_ign_ff;
   assign rsp_window_base  = out_base_ff;
   assign rsp_done_res     = out_done_ff;

endmodule

`default_nettype wire

/* src/go_back_n_sender_window_top.sv */
// ----------------------------------------------------------------------------
// Go-Back-N sender window, top level
// Flow: each request is captured, evaluated, walks a re-mark span of the k
// sequences re-marked by a cumulative ack or a go-back, and is handed over.
// Requests: a new one is taken only once the last result is handed over;
// k is at most SEQ_SPACE - 1 and the span walker re-marks one sequence per
// cycle. A result that the receiver has not yet taken holds the next one,
// and so the input. Reset: synchronous; all marks set, window and counters
// cleared, configuration registers at their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_window_top #(
   parameter int SEQ_SPACE = gbn_pkg::SEQ_SPACE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [gbn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gbn_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [gbn_pkg::REQ_TYPE_W-1:0] req_type,
   input  wire logic [gbn_pkg::ACK_W-1:0]      req_ack_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_send_valid,
   output logic [gbn_pkg::SEQ_OUT_W-1:0]       rsp_send_seq,
   output logic [gbn_pkg::PKT_W-1:0]           rsp_packet_index,
   output logic                                rsp_timed_out,
   output logic                                rsp_ack_ignored,
   output logic [gbn_pkg::SEQ_OUT_W-1:0]       rsp_window_base,
   output logic                                rsp_done_res
);
   import gbn_pkg::*;

   gbn_cmd_type    cmd;
   gbn_status_type status;

   // Controller.
   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   gbn_datapath #(
      .SEQ_SPACE (SEQ_SPACE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_type         (req_type),
      .req_ack_value    (req_ack_value),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_send_valid   (rsp_send_valid),
      .rsp_send_seq     (rsp_send_seq),
      .rsp_packet_index (rsp_packet_index),
      .rsp_timed_out    (rsp_timed_out),
      .rsp_ack_ignored  (rsp_ack_ignored),
      .rsp_window_base  (rsp_window_base),
      .rsp_done_res     (rsp_done_res),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire
